[rtl/hcbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, character codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT = 24;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Results of one item: none, one passed byte, or the four-byte terminator.
   localparam logic [2:0] RUN_NONE = 3'd0;
   localparam logic [2:0] RUN_ONE  = 3'd1;
   localparam logic [2:0] RUN_TERM = 3'd4;

   typedef enum logic [2:0] {
      MODE_HEADER = 3'd0,
      MODE_SIZE   = 3'd1,
      MODE_LINE   = 3'd2,
      MODE_DATA   = 3'd3,
      MODE_SKIP   = 3'd4,
      MODE_DONE   = 3'd5
   } mode_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   // Decode one ASCII hex digit; anything else reports is_hex low.
   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type d;
      d.is_hex = 1'b0;
      d.value  = 4'd0;
      if (b inside {[8'h30:8'h39]}) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h30);
      end else if (b inside {[8'h61:8'h66]}) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h57);
      end else if (b inside {[8'h41:8'h46]}) begin
         d.is_hex = 1'b1;
         d.value  = 4'(b - 8'h37);
      end
      return d;
   endfunction

endpackage
`default_nettype wire

[rtl/http_chunked_body_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-wide HTTP/1.1 chunked transfer decoder with header pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw message byte per item; req_message_start marks the
//   first byte of a new message and restarts parsing in header mode.
//   rsp_* carries decoded bytes: header bytes, chunk data bytes, and the
//   CR LF CR LF terminator (four items, the last with rsp_message_end).
//   Size digits, size line, chunk trailer and bytes after the end give no item.
//   rsp_last_of_run marks the last result of one input item.
// Timing:
//   An accepted item is held in an input register, decoded combinationally and
//   written into the result register, which drives the rsp side.
//   One byte per cycle sustained while rsp_ready is high, but the terminator's
//   four results occupy the result register until all four are taken.
//   Items that produce no result retire without waiting on the rsp side.
// Reset / stall:
//   reset (synchronous, active high) clears parsing state to header mode and
//   empties both registers. When rsp_ready is low the result holds, and the
//   input register fills and then drops req_ready.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_message_start,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_last_of_run,
   output      logic       rsp_message_end,
   output      logic       rsp_size_overflow
);

   localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Parsing state
   mode_type             mode_ff,      mode_in;
   logic [1:0]           hdr_cnt_ff,   hdr_cnt_in;
   logic [SIZE_BITS-1:0] size_acc_ff,  size_acc_in;
   logic [SIZE_BITS-1:0] data_rem_ff,  data_rem_in;
   logic                 saw_cr_ff,    saw_cr_in;
   logic [1:0]           skip_cnt_ff,  skip_cnt_in;
   logic                 ovf_ff,       ovf_in;

   // Result register: a run of up to four results for one item
   logic [2:0] run_cnt_ff,  run_cnt_in;
   logic       run_term_ff, run_term_in;
   logic [7:0] run_byte_ff, run_byte_in;
   logic       run_ovf_ff,  run_ovf_in;

   // Decode signals
   mode_type             cur_mode;
   logic [1:0]           cur_hdr_cnt;
   logic [SIZE_BITS-1:0] cur_size_acc;
   logic                 cur_ovf;
   logic [2:0]           n_res;
   logic                 n_term;
   hex_digit_type        hex;
   logic [SIZE_BITS-1:0] rem_dec;
   logic                 rsp_fire;
   logic                 out_free;
   logic                 advance;

   assign rsp_fire = rsp_valid && rsp_ready;
   assign out_free = (run_cnt_ff == RUN_NONE) || ((run_cnt_ff == RUN_ONE) && rsp_ready);
   // Retire the held item when its results fit, or when it has none
   assign advance   = in_valid_ff && ((n_res == RUN_NONE) || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_in_byte;
         in_start_ff <= req_message_start;
      end
   end

   // Message start clears the state before the byte is handled
   assign cur_mode     = in_start_ff ? MODE_HEADER : mode_ff;
   assign cur_hdr_cnt  = in_start_ff ? 2'd0 : hdr_cnt_ff;
   assign cur_size_acc = in_start_ff ? '0 : size_acc_ff;
   assign cur_ovf      = in_start_ff ? 1'b0 : ovf_ff;
   assign hex          = hex_decode(in_byte_ff);
   assign rem_dec      = data_rem_ff - SIZE_BITS'(1);

   always_comb begin
      mode_in     = cur_mode;
      hdr_cnt_in  = cur_hdr_cnt;
      size_acc_in = cur_size_acc;
      data_rem_in = data_rem_ff;
      saw_cr_in   = in_start_ff ? 1'b0 : saw_cr_ff;
      skip_cnt_in = in_start_ff ? 2'd0 : skip_cnt_ff;
      ovf_in      = cur_ovf;
      n_res       = RUN_NONE;
      n_term      = 1'b0;
      case (cur_mode)
         MODE_HEADER: begin
            n_res = RUN_ONE;
            // Track progress through CR LF CR LF
            if (in_byte_ff == (cur_hdr_cnt[0] ? CH_LF : CH_CR)) begin
               if (cur_hdr_cnt == 2'd3) begin
                  hdr_cnt_in  = 2'd0;
                  mode_in     = MODE_SIZE;
                  size_acc_in = '0;
               end else begin
                  hdr_cnt_in = cur_hdr_cnt + 2'd1;
               end
            end else begin
               hdr_cnt_in = (in_byte_ff == CH_CR) ? 2'd1 : 2'd0;
            end
         end
         MODE_SIZE: begin
            if (hex.is_hex) begin
               // Saturate when the shift would push out a set bit
               if (cur_size_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                  size_acc_in = SIZE_MAX;
                  ovf_in      = 1'b1;
               end else begin
                  size_acc_in = {cur_size_acc[SIZE_BITS-5:0], hex.value};
               end
            end else if (cur_size_acc == '0) begin
               mode_in = MODE_DONE;
               n_res   = RUN_TERM;
               n_term  = 1'b1;
            end else begin
               data_rem_in = cur_size_acc;
               saw_cr_in   = (in_byte_ff == CH_CR);
               mode_in     = MODE_LINE;
            end
         end
         MODE_LINE: begin
            if (in_byte_ff == CH_LF && saw_cr_ff) begin
               saw_cr_in = 1'b0;
               mode_in   = MODE_DATA;
            end else begin
               saw_cr_in = (in_byte_ff == CH_CR);
            end
         end
         MODE_DATA: begin
            n_res       = RUN_ONE;
            data_rem_in = rem_dec;
            if (rem_dec == '0) begin
               skip_cnt_in = 2'd2;
               mode_in     = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            skip_cnt_in = skip_cnt_ff - 2'd1;
            if (skip_cnt_in == 2'd0) begin
               size_acc_in = '0;
               mode_in     = MODE_SIZE;
            end
         end
         default: begin
            // After the end: drop everything
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_HEADER;
         hdr_cnt_ff  <= 2'd0;
         size_acc_ff <= '0;
         data_rem_ff <= '0;
         saw_cr_ff   <= 1'b0;
         skip_cnt_ff <= 2'd0;
         ovf_ff      <= 1'b0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         size_acc_ff <= size_acc_in;
         data_rem_ff <= data_rem_in;
         saw_cr_ff   <= saw_cr_in;
         skip_cnt_ff <= skip_cnt_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Result register: load a new run, or count down the current one
   always_comb begin
      run_cnt_in  = run_cnt_ff;
      run_term_in = run_term_ff;
      run_byte_in = run_byte_ff;
      run_ovf_in  = run_ovf_ff;
      if (rsp_fire) begin
         run_cnt_in = run_cnt_ff - 3'd1;
      end
      if (advance && (n_res != RUN_NONE)) begin
         run_cnt_in  = n_res;
         run_term_in = n_term;
         run_byte_in = in_byte_ff;
         run_ovf_in  = cur_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff <= RUN_NONE;
      end else begin
         run_cnt_ff <= run_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      run_term_ff <= run_term_in;
      run_byte_ff <= run_byte_in;
      run_ovf_ff  <= run_ovf_in;
   end

   // Terminator walks CR, LF, CR, LF as the count goes 4, 3, 2, 1
   assign rsp_valid         = (run_cnt_ff != RUN_NONE);
   assign rsp_out_byte      = run_term_ff ? (run_cnt_ff[0] ? CH_LF : CH_CR) : run_byte_ff;
   assign rsp_last_of_run   = (run_cnt_ff == RUN_ONE);
   assign rsp_message_end   = run_term_ff && (run_cnt_ff == RUN_ONE);
   assign rsp_size_overflow = run_ovf_ff;

   // Checks
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_cnt_ff <= RUN_TERM)
      else $error("result run count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && n_res != RUN_NONE) |->
         (run_cnt_ff == RUN_NONE || (run_cnt_ff == RUN_ONE && rsp_ready)))
      else $error("result run overwritten before delivery");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> data_rem_ff != '0)
      else $error("data mode with no bytes remaining");

   a_end_is_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_message_end) |-> (mode_ff == MODE_DONE || in_valid_ff))
      else $error("message end without terminated parse");

endmodule
`default_nettype wire
